// ----- rtl/core/dps_pkg.sv -----
// Shared types and constants for the display pattern sequencer.
// Used by every module under rtl/core; depends on nothing.
package dps_pkg;

    localparam int MAX_PATTERNS = 16;
    localparam int IDX_W        = 4;
    localparam int CNT_W        = 5;
    localparam int TIME_W       = 32;
    localparam int FRAME_W      = 10;
    localparam int OP_W         = 3;
    localparam int ID_W         = 8;
    localparam int DIV_W        = 8;
    localparam int DIV_CNT_W    = $clog2(DIV_W + 1);
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;

    localparam logic [CNT_W-1:0]   MAX_COUNT   = CNT_W'(MAX_PATTERNS);
    localparam logic [FRAME_W-1:0] FRAME_RESET = FRAME_W'(33);

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATE_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD  = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 3'd0,
        OP_NEXT   = 3'd1,
        OP_PREV   = 3'd2,
        OP_SWITCH = 3'd3,
        OP_START  = 3'd4,
        OP_CANCEL = 3'd5
    } op_t;

    typedef struct packed {
        logic capture;
        logic mod_start;
        logic commit;
    } dps_cmd_t;

    typedef struct packed {
        logic need_mod;
        logic mod_done;
        logic out_free;
    } dps_status_t;

endpackage

// ----- rtl/core/dps_mod.sv -----
// Serial remainder unit: dividend modulo a small divisor, one bit per cycle.
// Depends on dps_pkg.
module dps_mod (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [dps_pkg::DIV_W-1:0]  dividend,
    input  logic [dps_pkg::CNT_W-1:0]  divisor,
    output logic                       done,
    output logic [dps_pkg::CNT_W-1:0]  rem
);

    logic                          busy_reg;
    logic                          busy_next;
    logic                          done_reg;
    logic                          done_next;
    logic [dps_pkg::DIV_CNT_W-1:0] step_reg;
    logic [dps_pkg::DIV_CNT_W-1:0] step_next;
    logic [dps_pkg::DIV_W-1:0]     shift_reg;
    logic [dps_pkg::DIV_W-1:0]     shift_next;
    logic [dps_pkg::CNT_W-1:0]     rem_reg;
    logic [dps_pkg::CNT_W-1:0]     rem_next;
    logic [dps_pkg::CNT_W:0]       trial;
    logic [dps_pkg::CNT_W:0]       divisor_ext;

    assign divisor_ext = {1'b0, divisor};
    assign trial       = {rem_reg, shift_reg[dps_pkg::DIV_W-1]};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        step_next  = step_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            step_next  = dps_pkg::DIV_CNT_W'(dps_pkg::DIV_W);
            shift_next = dividend;
            rem_next   = '0;
        end
        else if (busy_reg)
        begin
            step_next  = step_reg - dps_pkg::DIV_CNT_W'(1);
            shift_next = {shift_reg[dps_pkg::DIV_W-2:0], 1'b0};
            if (trial >= divisor_ext)
            begin
                rem_next = dps_pkg::CNT_W'(trial - divisor_ext);
            end
            else
            begin
                rem_next = trial[dps_pkg::CNT_W-1:0];
            end
            if (step_reg == dps_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < divisor))
        else $error("remainder not below divisor");

endmodule

// ----- rtl/core/dps_datapath.sv -----
// Datapath: configuration, sequencer state, item latch, decisions and result register.
// Depends on dps_pkg and dps_mod.
module dps_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  dps_pkg::dps_cmd_t               cmd,
    output dps_pkg::dps_status_t            status,
    input  logic                            cfg_write,
    input  logic [dps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dps_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [dps_pkg::OP_W-1:0]        opcode,
    input  logic [dps_pkg::TIME_W-1:0]      now_ms,
    input  logic [dps_pkg::DIV_W-1:0]       target_index,
    input  logic [dps_pkg::ID_W-1:0]        override_id,
    input  logic [dps_pkg::TIME_W-1:0]      duration_ms,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            override_active,
    output logic [dps_pkg::IDX_W-1:0]       active_index,
    output logic [dps_pkg::ID_W-1:0]        active_override,
    output logic                            restarted,
    output logic                            updated,
    output logic                            shown
);

    // configuration
    logic [dps_pkg::CNT_W-1:0]   count_reg;
    logic [dps_pkg::TIME_W-1:0]  rotate_reg;
    logic [dps_pkg::FRAME_W-1:0] frame_reg;

    // latched item
    logic [dps_pkg::OP_W-1:0]    op_reg;
    logic [dps_pkg::TIME_W-1:0]  now_reg;
    logic [dps_pkg::DIV_W-1:0]   tgt_reg;
    logic [dps_pkg::ID_W-1:0]    oid_reg;
    logic [dps_pkg::TIME_W-1:0]  dur_reg;

    // sequencer state
    logic                        in_ov_reg,      in_ov_next;
    logic [dps_pkg::IDX_W-1:0]   cur_reg,        cur_next;
    logic [dps_pkg::IDX_W-1:0]   resume_reg,     resume_next;
    logic [dps_pkg::ID_W-1:0]    ovp_reg,        ovp_next;
    logic [dps_pkg::TIME_W-1:0]  deadline_reg,   deadline_next;
    logic [dps_pkg::TIME_W-1:0]  last_sw_reg,    last_sw_next;
    logic [dps_pkg::TIME_W-1:0]  last_show_reg,  last_show_next;

    // result flags
    logic                        out_valid_reg,  out_valid_next;
    logic                        rst_flag_reg,   rst_flag_next;
    logic                        upd_reg,        upd_next;
    logic                        shw_reg,        shw_next;

    logic [dps_pkg::CNT_W-1:0]   eff_cnt;
    logic                        cnt_nz;
    logic [dps_pkg::TIME_W-1:0]  diff_deadline;
    logic                        expired;
    logic                        rot_due;
    logic                        show_due;
    logic                        go;
    logic [dps_pkg::DIV_W-1:0]   dividend;
    logic [dps_pkg::DIV_W-1:0]   cur_ext;
    logic [dps_pkg::TIME_W-1:0]  dur_eff;
    logic                        mod_done;
    logic [dps_pkg::CNT_W-1:0]   mod_rem;

    assign eff_cnt       = (count_reg > dps_pkg::MAX_COUNT) ? dps_pkg::MAX_COUNT : count_reg;
    assign cnt_nz        = (eff_cnt != '0);
    assign diff_deadline = now_reg - deadline_reg;
    assign expired       = ~diff_deadline[dps_pkg::TIME_W-1];
    assign rot_due       = (rotate_reg != '0) && ((now_reg - last_sw_reg) >= rotate_reg);
    assign show_due      = ((now_reg - last_show_reg)
                           >= {{(dps_pkg::TIME_W-dps_pkg::FRAME_W){1'b0}}, frame_reg});
    assign cur_ext       = {{(dps_pkg::DIV_W-dps_pkg::IDX_W){1'b0}}, cur_reg};
    assign dur_eff       = (dur_reg == '0) ? dps_pkg::TIME_W'(1) : dur_reg;

    // whether this item moves the list index, and the value reduced modulo the count
    always_comb
    begin
        go       = 1'b0;
        dividend = cur_ext + dps_pkg::DIV_W'(1);
        unique case (dps_pkg::op_t'(op_reg))
            dps_pkg::OP_TICK:
            begin
                if (in_ov_reg)
                begin
                    go       = expired && cnt_nz;
                    dividend = {{(dps_pkg::DIV_W-dps_pkg::IDX_W){1'b0}}, resume_reg};
                end
                else
                begin
                    go = cnt_nz && rot_due;
                end
            end
            dps_pkg::OP_NEXT:
            begin
                go = cnt_nz;
            end
            dps_pkg::OP_PREV:
            begin
                go       = cnt_nz;
                dividend = cur_ext + {{(dps_pkg::DIV_W-dps_pkg::CNT_W){1'b0}}, eff_cnt}
                           - dps_pkg::DIV_W'(1);
            end
            dps_pkg::OP_SWITCH:
            begin
                go       = cnt_nz;
                dividend = tgt_reg;
            end
            dps_pkg::OP_CANCEL:
            begin
                go       = in_ov_reg && cnt_nz;
                dividend = {{(dps_pkg::DIV_W-dps_pkg::IDX_W){1'b0}}, resume_reg};
            end
            default:
            begin
                go = 1'b0;
            end
        endcase
    end

    dps_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.mod_start),
        .dividend (dividend),
        .divisor  (eff_cnt),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    assign status.need_mod = go;
    assign status.mod_done = mod_done;
    assign status.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        in_ov_next     = in_ov_reg;
        cur_next       = cur_reg;
        resume_next    = resume_reg;
        ovp_next       = ovp_reg;
        deadline_next  = deadline_reg;
        last_sw_next   = last_sw_reg;
        last_show_next = last_show_reg;
        rst_flag_next  = 1'b0;
        upd_next       = 1'b0;
        shw_next       = 1'b0;
        if (go)
        begin
            cur_next      = mod_rem[dps_pkg::IDX_W-1:0];
            last_sw_next  = now_reg;
            rst_flag_next = 1'b1;
        end
        unique case (dps_pkg::op_t'(op_reg))
            dps_pkg::OP_TICK:
            begin
                if (in_ov_reg || cnt_nz)
                begin
                    if (in_ov_reg && expired)
                    begin
                        in_ov_next = 1'b0;
                        ovp_next   = '0;
                    end
                    else
                    begin
                        upd_next = 1'b1;
                    end
                    if (show_due)
                    begin
                        shw_next       = 1'b1;
                        last_show_next = now_reg;
                    end
                end
            end
            dps_pkg::OP_START:
            begin
                if (!in_ov_reg && cnt_nz)
                begin
                    resume_next = cur_reg;
                end
                ovp_next      = oid_reg;
                in_ov_next    = 1'b1;
                deadline_next = now_reg + dur_eff;
                last_sw_next  = now_reg;
                rst_flag_next = 1'b1;
            end
            dps_pkg::OP_CANCEL:
            begin
                if (in_ov_reg)
                begin
                    in_ov_next = 1'b0;
                    ovp_next   = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rotate_reg    <= '0;
            frame_reg     <= dps_pkg::FRAME_RESET;
            in_ov_reg     <= 1'b0;
            cur_reg       <= '0;
            resume_reg    <= '0;
            ovp_reg       <= '0;
            deadline_reg  <= '0;
            last_sw_reg   <= '0;
            last_show_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    dps_pkg::CFG_PATTERN_COUNT: count_reg  <= cfg_data[dps_pkg::CNT_W-1:0];
                    dps_pkg::CFG_ROTATE_PERIOD: rotate_reg <= cfg_data[dps_pkg::TIME_W-1:0];
                    dps_pkg::CFG_FRAME_PERIOD:  frame_reg  <= cfg_data[dps_pkg::FRAME_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.commit)
            begin
                in_ov_reg     <= in_ov_next;
                cur_reg       <= cur_next;
                resume_reg    <= resume_next;
                ovp_reg       <= ovp_next;
                deadline_reg  <= deadline_next;
                last_sw_reg   <= last_sw_next;
                last_show_reg <= last_show_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= opcode;
            now_reg <= now_ms;
            tgt_reg <= target_index;
            oid_reg <= override_id;
            dur_reg <= duration_ms;
        end
        if (cmd.commit)
        begin
            rst_flag_reg <= rst_flag_next;
            upd_reg      <= upd_next;
            shw_reg      <= shw_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign override_active = in_ov_reg;
    assign active_index    = cur_reg;
    assign active_override = ovp_reg;
    assign restarted       = rst_flag_reg;
    assign updated         = upd_reg;
    assign shown           = shw_reg;

    a_override_id_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ov_reg |-> (ovp_reg == '0))
        else $error("override id left set outside override");

    a_mod_nonzero_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mod_start |-> cnt_nz)
        else $error("remainder started with empty list");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !cmd.commit)
        else $error("pending result overwritten");

endmodule

// ----- rtl/core/dps_ctrl.sv -----
// Controller state machine: item capture, remainder launch and commit sequencing.
// Depends on dps_pkg.
module dps_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  dps_pkg::dps_status_t  status,
    output dps_pkg::dps_cmd_t     cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EVAL   = 4'b0010,
        S_DIV    = 4'b0100,
        S_COMMIT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (status.need_mod)
                begin
                    cmd.mod_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    state_next = S_COMMIT;
                end
            end
            S_DIV:
            begin
                if (status.mod_done)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    a_done_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        status.mod_done |-> (state_reg == S_DIV))
        else $error("remainder done outside wait state");

endmodule

// ----- rtl/core/display_pattern_sequencer.sv -----
// Display pattern sequencer: picks the active list pattern or timed override per opcode
// item. An item is captured, evaluated and committed to the result register; when the list
// index is recomputed, the 8-step serial remainder unit reduces it modulo the pattern count
// before the commit. The result sits in an output register, so a new item is taken while
// it waits. No clearing pass after reset. Depends on dps_pkg, dps_ctrl and dps_datapath.
module display_pattern_sequencer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [dps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dps_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [dps_pkg::OP_W-1:0]        opcode,
    input  logic [dps_pkg::TIME_W-1:0]      now_ms,
    input  logic [dps_pkg::DIV_W-1:0]       target_index,
    input  logic [dps_pkg::ID_W-1:0]        override_id,
    input  logic [dps_pkg::TIME_W-1:0]      duration_ms,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            override_active,
    output logic [dps_pkg::IDX_W-1:0]       active_index,
    output logic [dps_pkg::ID_W-1:0]        active_override,
    output logic                            restarted,
    output logic                            updated,
    output logic                            shown
);

    dps_pkg::dps_cmd_t    cmd;
    dps_pkg::dps_status_t status;

    dps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    dps_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .opcode          (opcode),
        .now_ms          (now_ms),
        .target_index    (target_index),
        .override_id     (override_id),
        .duration_ms     (duration_ms),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .override_active (override_active),
        .active_index    (active_index),
        .active_override (active_override),
        .restarted       (restarted),
        .updated         (updated),
        .shown           (shown)
    );

endmodule
